// ===== design/momentum_residual_point_unit_defines.svh =====
// Assertion helpers shared by the block's modules.
// Each helper checks on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef MOMENTUM_RESIDUAL_POINT_UNIT_DEFINES_SVH
`define MOMENTUM_RESIDUAL_POINT_UNIT_DEFINES_SVH

// The condition holds in the same cycle as the trigger.
`define MRP_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error(msg);

// The condition holds in the cycle after the trigger.
`define MRP_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

// ===== design/mrp_pkg.sv =====
`timescale 1ns / 1ps

package mrp_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned REG_W    = 31;
    localparam int unsigned IDX_W    = 2;
    // Rounded Q16.16 product, and the sum of up to three of them.
    localparam int unsigned TERM_W   = 49;
    localparam int unsigned SUM_W    = 51;
    localparam int unsigned CNT_W    = 5;

    localparam logic [REG_W-1:0] STROUHAL_RESET  = 31'd65536;
    localparam logic [REG_W-1:0] VISCOSITY_RESET = 31'd65536;
    localparam logic [REG_W-1:0] REYNOLDS_RESET  = 31'd65536;
    localparam logic [REG_W-1:0] COEF_RESET      = 31'd65536;
    localparam logic [REG_W-1:0] COEF_MAX        = 31'h7FFF_FFFF;

    // Register indexes on the configuration channel.
    typedef enum logic [IDX_W-1:0] {
        REG_STROUHAL  = 2'd0,
        REG_VISCOSITY = 2'd1,
        REG_REYNOLDS  = 2'd2
    } t_reg_idx;

    // Settings that the datapath needs, plus the divider status.
    typedef struct packed {
        logic [REG_W-1:0] strouhal;
        logic [REG_W-1:0] coef;
        logic             busy;
    } t_cfg_state;

    // Multiply and round to nearest Q16.16, ties toward plus infinity.
    function automatic logic signed [TERM_W-1:0] mul_round(
        input logic signed [32:0] a,
        input logic signed [33:0] b
    );
        logic signed [66:0] p;
        logic signed [66:0] q;
        p = 67'(a) * 67'(b);
        q = p + 67'sd32768;
        return q[64:16];
    endfunction

    // Clamp a wide sum to the signed 32-bit range.
    function automatic logic [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [WORD_W-1:0] r;
        if (v > 51'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -51'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    // Widen a rounded term to the sum width.
    function automatic logic signed [SUM_W-1:0] ext_term(input logic signed [TERM_W-1:0] t);
        return {{(SUM_W-TERM_W){t[TERM_W-1]}}, t};
    endfunction

endpackage

// ===== design/mrp_coef_div.sv =====
`timescale 1ns / 1ps

`include "momentum_residual_point_unit_defines.svh"

// Restoring divider for K = floor((viscosity << 16) / reynolds), saturated to 31 bits.
module mrp_coef_div
    import mrp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [REG_W-1:0] i_viscosity,
    input  logic [REG_W-1:0] i_reynolds,
    output logic             o_busy,
    output logic [REG_W-1:0] o_coef
);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [REG_W-1:0] r_rem;
    logic [REG_W-1:0] r_low;
    logic [REG_W-1:0] r_quot;
    logic [REG_W-1:0] r_div;
    logic [REG_W-1:0] r_coef;

    logic [15:0]      hi_part;
    logic             overflow;
    logic [REG_W:0]   trial;
    logic             qbit;
    logic [REG_W-1:0] n_rem;

    // The quotient needs more than 31 bits exactly when the top 16 dividend
    // bits already reach the divisor; a zero divisor lands here as well.
    assign hi_part  = i_viscosity[REG_W-1:15];
    assign overflow = {15'd0, hi_part} >= i_reynolds;

    // One quotient bit per cycle.
    always_comb begin
        trial = {r_rem, r_low[REG_W-1]};
        qbit  = trial >= {1'b0, r_div};
        if (qbit) begin
            n_rem = REG_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[REG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_coef <= COEF_RESET;
        end else if (i_start) begin
            if (overflow) begin
                r_busy <= 1'b0;
                r_coef <= COEF_MAX;
            end else begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(REG_W - 1);
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_coef <= {r_quot[REG_W-2:0], qbit};
            end
        end
    end

    // Working registers of the division.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {15'd0, hi_part};
            r_low <= {i_viscosity[14:0], 16'd0};
            r_div <= i_reynolds;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_low  <= {r_low[REG_W-2:0], 1'b0};
            r_quot <= {r_quot[REG_W-2:0], qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_coef = r_coef;

    `MRP_ASSERT_NEXT(a_sat_short, i_start && overflow, !r_busy && r_coef == COEF_MAX, "saturated coefficient not taken in one cycle")
    `MRP_ASSERT_NEXT(a_div_ends, r_busy && !i_start && r_cnt == '0, !r_busy, "divider did not stop after the last quotient bit")

endmodule

// ===== design/mrp_cfg_regs.sv =====
`timescale 1ns / 1ps

// Configuration registers and the viscous coefficient they derive.
module mrp_cfg_regs
    import mrp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [IDX_W-1:0] i_index,
    input  logic [REG_W-1:0] i_data,
    output t_cfg_state       o_cfg
);

    logic [REG_W-1:0] r_strouhal;
    logic [REG_W-1:0] r_viscosity;
    logic [REG_W-1:0] r_reynolds;
    logic             r_start;
    logic             div_busy;
    logic [REG_W-1:0] coef;

    // Register writes; a known index restarts the coefficient divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strouhal  <= STROUHAL_RESET;
            r_viscosity <= VISCOSITY_RESET;
            r_reynolds  <= REYNOLDS_RESET;
            r_start     <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (i_wr) begin
                case (i_index)
                    REG_STROUHAL: begin
                        r_strouhal <= i_data;
                        r_start    <= 1'b1;
                    end
                    REG_VISCOSITY: begin
                        r_viscosity <= i_data;
                        r_start     <= 1'b1;
                    end
                    REG_REYNOLDS: begin
                        r_reynolds <= i_data;
                        r_start    <= 1'b1;
                    end
                    default: begin
                        r_start <= 1'b0;
                    end
                endcase
            end
        end
    end

    mrp_coef_div u_coef_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_start),
        .i_viscosity (r_viscosity),
        .i_reynolds  (r_reynolds),
        .o_busy      (div_busy),
        .o_coef      (coef)
    );

    assign o_cfg.strouhal = r_strouhal;
    assign o_cfg.coef     = coef;
    assign o_cfg.busy     = r_start | div_busy;

endmodule

// ===== design/mrp_datapath.sv =====
`timescale 1ns / 1ps

`include "momentum_residual_point_unit_defines.svh"

// Three-register pipeline: input register, rounded products, saturated results.
module mrp_datapath
    import mrp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg_state          i_cfg,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  logic [9*WORD_W-1:0] i_s_data,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output logic [6*WORD_W-1:0] o_m_data,
    output logic                o_idle
);

    logic en1, en2, en3, accept;
    logic r_v1, r_v2, r_v3;

    logic signed [WORD_W-1:0] r_vel_x, r_vel_y, r_rate_x, r_rate_y;
    logic signed [WORD_W-1:0] r_dvx_dx, r_dvx_dy, r_dvy_dx, r_dvy_dy, r_pres1;

    logic signed [TERM_W-1:0] r_st_x, r_st_y;
    logic signed [TERM_W-1:0] r_cv_xx, r_cv_xy, r_cv_yx, r_cv_yy;
    logic signed [TERM_W-1:0] r_vs_xx, r_vs_xy, r_vs_yy;
    logic signed [WORD_W-1:0] r_pres2;

    logic [6*WORD_W-1:0] r_out;

    logic signed [32:0] strouhal_s, coef_s;
    logic signed [33:0] sum_xx, sum_xy, sum_yy;
    logic signed [SUM_W-1:0] f_x, f_y, s_xx, s_yy, pres_w;

    // Each stage loads when it is empty or its content moves on.
    assign en3       = !r_v3 || i_m_ready;
    assign en2       = !r_v2 || en3;
    assign en1       = !r_v1 || en2;
    assign o_s_ready = en1 && !i_cfg.busy;
    assign accept    = i_s_valid && o_s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (en1 && accept) begin
            r_vel_x  <= i_s_data[0*WORD_W +: WORD_W];
            r_vel_y  <= i_s_data[1*WORD_W +: WORD_W];
            r_rate_x <= i_s_data[2*WORD_W +: WORD_W];
            r_rate_y <= i_s_data[3*WORD_W +: WORD_W];
            r_dvx_dx <= i_s_data[4*WORD_W +: WORD_W];
            r_dvx_dy <= i_s_data[5*WORD_W +: WORD_W];
            r_dvy_dx <= i_s_data[6*WORD_W +: WORD_W];
            r_dvy_dy <= i_s_data[7*WORD_W +: WORD_W];
            r_pres1  <= i_s_data[8*WORD_W +: WORD_W];
        end
    end

    // Gradient plus transpose is exact; the xy and yx entries share one sum.
    always_comb begin
        strouhal_s = $signed({2'b00, i_cfg.strouhal});
        coef_s     = $signed({2'b00, i_cfg.coef});
        sum_xx     = {{2{r_dvx_dx[WORD_W-1]}}, r_dvx_dx} + {{2{r_dvx_dx[WORD_W-1]}}, r_dvx_dx};
        sum_xy     = {{2{r_dvx_dy[WORD_W-1]}}, r_dvx_dy} + {{2{r_dvy_dx[WORD_W-1]}}, r_dvy_dx};
        sum_yy     = {{2{r_dvy_dy[WORD_W-1]}}, r_dvy_dy} + {{2{r_dvy_dy[WORD_W-1]}}, r_dvy_dy};
    end

    // Product register: each product rounded to Q16.16 on its own.
    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_st_x  <= mul_round(strouhal_s, {{2{r_rate_x[WORD_W-1]}}, r_rate_x});
            r_st_y  <= mul_round(strouhal_s, {{2{r_rate_y[WORD_W-1]}}, r_rate_y});
            r_cv_xx <= mul_round({r_vel_x[WORD_W-1], r_vel_x},
                                 {{2{r_dvx_dx[WORD_W-1]}}, r_dvx_dx});
            r_cv_xy <= mul_round({r_vel_y[WORD_W-1], r_vel_y},
                                 {{2{r_dvx_dy[WORD_W-1]}}, r_dvx_dy});
            r_cv_yx <= mul_round({r_vel_x[WORD_W-1], r_vel_x},
                                 {{2{r_dvy_dx[WORD_W-1]}}, r_dvy_dx});
            r_cv_yy <= mul_round({r_vel_y[WORD_W-1], r_vel_y},
                                 {{2{r_dvy_dy[WORD_W-1]}}, r_dvy_dy});
            r_vs_xx <= mul_round(coef_s, sum_xx);
            r_vs_xy <= mul_round(coef_s, sum_xy);
            r_vs_yy <= mul_round(coef_s, sum_yy);
            r_pres2 <= r_pres1;
        end
    end

    // Exact sums of the rounded terms, then clamp.
    always_comb begin
        pres_w = {{(SUM_W-WORD_W){r_pres2[WORD_W-1]}}, r_pres2};
        f_x    = ext_term(r_st_x) + ext_term(r_cv_xx) + ext_term(r_cv_xy);
        f_y    = ext_term(r_st_y) + ext_term(r_cv_yx) + ext_term(r_cv_yy);
        s_xx   = ext_term(r_vs_xx) - pres_w;
        s_yy   = ext_term(r_vs_yy) - pres_w;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_out[0*WORD_W +: WORD_W] <= sat32(f_x);
            r_out[1*WORD_W +: WORD_W] <= sat32(f_y);
            r_out[2*WORD_W +: WORD_W] <= sat32(s_xx);
            r_out[3*WORD_W +: WORD_W] <= sat32(ext_term(r_vs_xy));
            r_out[4*WORD_W +: WORD_W] <= sat32(ext_term(r_vs_xy));
            r_out[5*WORD_W +: WORD_W] <= sat32(s_yy);
        end
    end

    assign o_m_valid = r_v3;
    assign o_m_data  = r_out;
    assign o_idle    = !(r_v1 || r_v2 || r_v3);

    `MRP_ASSERT_SAME(a_coef_quiet, r_v1 || r_v2, !i_cfg.busy, "coefficient recomputed with a point in flight")
    `MRP_ASSERT_NEXT(a_result_held, r_v3 && !i_m_ready, r_v3 && $stable(r_out), "stalled result lost")

endmodule

// ===== design/momentum_residual_point_unit.sv =====
`timescale 1ns / 1ps

`include "momentum_residual_point_unit_defines.svh"

// Pointwise 2-D momentum residual in signed Q16.16: one quadrature point per beat in,
// one beat out with the value term (force) and the gradient term (stress), all outputs
// saturated. The datapath takes one point every cycle unless the output stalls or the
// coefficient is being recomputed, and holds up to three in flight; a point moves from
// the input register to the rounded-product register to the result register, where
// its result waits until taken. Writing strouhal, viscosity or reynolds recomputes
// K = viscosity/reynolds in a bit-serial divider, one quotient bit per cycle; while
// the write is registered and while the divider runs, neither points nor further
// register writes are taken (a saturating ratio skips the division). Register writes
// are taken only while no point is in flight and none is offered on the input.
module momentum_residual_point_unit
    import mrp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input point: vel_x, vel_y, rate_x, rate_y, dvx_dx, dvx_dy, dvy_dx, dvy_dy, pressure
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [9*WORD_W-1:0] s_axis_tdata,
    // Result: force_x, force_y, stress_xx, stress_xy, stress_yx, stress_yy
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [6*WORD_W-1:0] m_axis_tdata,
    // Register write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [REG_W-1:0]    i_cfg_data
);

    t_cfg_state cfg;
    logic       dp_idle;
    logic       cfg_wr;

    // Register writes wait for an empty pipeline, an idle divider and no offered point,
    // so a write never shares an edge with an input beat.
    assign o_cfg_ready = dp_idle && !cfg.busy && !s_axis_tvalid;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    mrp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cfg_wr),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    mrp_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_s_data  (s_axis_tdata),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (m_axis_tdata),
        .o_idle    (dp_idle)
    );

    `MRP_ASSERT_NEXT(a_write_blocks_input, cfg_wr && i_cfg_index != REG_REYNOLDS + 2'd1, !s_axis_tready, "point accepted before the coefficient update")

endmodule
